// ===== hdl/kmer_invertible_hash_codec_assert.svh =====
// Assertion macros for the k-mer hash codec.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef KMER_INVERTIBLE_HASH_CODEC_ASSERT_SVH
`define KMER_INVERTIBLE_HASH_CODEC_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KIHC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KIHC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kihc_pkg.sv =====
// Types, constants and microprogram for the k-mer invertible hash codec.
// No dependencies.
`default_nettype none

package kihc_pkg;

	localparam int unsigned MAX_K = 32;

	localparam logic [63:0] INV21  = 64'd14933078535860113213;
	localparam logic [63:0] INV265 = 64'd15244667743933553977;

	localparam logic [5:0] KMER_LENGTH_RESET = 6'd31;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_G = 8'h47;

	localparam logic CMD_HASH   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic KIND_HASH = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

	typedef struct packed {
		logic        command;
		logic [7:0]  symbol;
		logic        end_of_kmer;
		logic [63:0] hash_in;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] hash_out;
		logic [7:0]  char_out;
		logic        bad_symbol;
		logic        final_res;
	} result_t;

	// Operand selects of the shared unit
	localparam logic [1:0] X_V  = 2'd0;
	localparam logic [1:0] X_T  = 2'd1;
	localparam logic [1:0] X_NV = 2'd2;
	localparam logic [1:0] X_P  = 2'd3;

	localparam logic [2:0] Y_V    = 3'd0;
	localparam logic [2:0] Y_T    = 3'd1;
	localparam logic [2:0] Y_NV   = 3'd2;
	localparam logic [2:0] Y_P    = 3'd3;
	localparam logic [2:0] Y_ZERO = 3'd4;

	localparam logic [1:0] FN_ADD = 2'd0;
	localparam logic [1:0] FN_SUB = 2'd1;
	localparam logic [1:0] FN_XOR = 2'd2;

	localparam logic [1:0] D_NONE = 2'd0;
	localparam logic [1:0] D_V    = 2'd1;
	localparam logic [1:0] D_T    = 2'd2;

	localparam logic C_INV21  = 1'b0;
	localparam logic C_INV265 = 1'b1;

	localparam logic [4:0] UC_FWD_START = 5'd0;
	localparam logic [4:0] UC_INV_START = 5'd9;
	localparam logic [4:0] UC_LAST      = 5'd29;

	typedef struct packed {
		logic [1:0] xsel;
		logic [2:0] ysel;
		logic       shl;
		logic [5:0] shamt;
		logic [1:0] fn;
		logic       inv;
		logic       msk;
		logic [1:0] dst;
		logic       mul_en;
		logic       mul_vhi;
		logic       mul_chi;
		logic       mul_csel;
		logic       last;
	} uop_t;

	function automatic uop_t alu_op(logic [1:0] xsel, logic [2:0] ysel, logic shl,
			logic [5:0] shamt, logic [1:0] fn, logic inv, logic msk, logic [1:0] dst,
			logic last);
		uop_t u;
		u          = '0;
		u.xsel     = xsel;
		u.ysel     = ysel;
		u.shl      = shl;
		u.shamt    = shamt;
		u.fn       = fn;
		u.inv      = inv;
		u.msk      = msk;
		u.dst      = dst;
		u.last     = last;
		return u;
	endfunction

	// Four-step constant multiply, mod 2^64, from 32x32 partial products.
	// step 0: p = vL*cL; 1: t = p, p = vL*cH; 2: t += p<<32, p = vH*cL; 3: v = t + p<<32
	function automatic uop_t mul_op(logic [1:0] step, logic csel);
		uop_t u;
		u          = '0;
		u.mul_csel = csel;
		unique case (step)
			2'd0: begin
				u.mul_en = 1'b1;
			end
			2'd1: begin
				u.xsel    = X_P;
				u.ysel    = Y_ZERO;
				u.fn      = FN_ADD;
				u.dst     = D_T;
				u.mul_en  = 1'b1;
				u.mul_chi = 1'b1;
			end
			2'd2: begin
				u.xsel    = X_T;
				u.ysel    = Y_P;
				u.shl     = 1'b1;
				u.shamt   = 6'd32;
				u.fn      = FN_ADD;
				u.dst     = D_T;
				u.mul_en  = 1'b1;
				u.mul_vhi = 1'b1;
			end
			default: begin
				u.xsel  = X_T;
				u.ysel  = Y_P;
				u.shl   = 1'b1;
				u.shamt = 6'd32;
				u.fn    = FN_ADD;
				u.msk   = 1'b1;
				u.dst   = D_V;
			end
		endcase
		return u;
	endfunction

	// Forward hash at 0..8, inverse hash at 9..29.
	function automatic uop_t ucode(logic [4:0] pc);
		uop_t u;
		unique case (pc)
			5'd0:  u = alu_op(X_NV, Y_V, 1'b1, 6'd21, FN_ADD, 1'b0, 1'b1, D_V, 1'b0);
			5'd1:  u = alu_op(X_V,  Y_V, 1'b0, 6'd24, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd2:  u = alu_op(X_V,  Y_V, 1'b1, 6'd3,  FN_ADD, 1'b0, 1'b0, D_T, 1'b0);
			5'd3:  u = alu_op(X_T,  Y_V, 1'b1, 6'd8,  FN_ADD, 1'b0, 1'b1, D_V, 1'b0);
			5'd4:  u = alu_op(X_V,  Y_V, 1'b0, 6'd14, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd5:  u = alu_op(X_V,  Y_V, 1'b1, 6'd2,  FN_ADD, 1'b0, 1'b0, D_T, 1'b0);
			5'd6:  u = alu_op(X_T,  Y_V, 1'b1, 6'd4,  FN_ADD, 1'b0, 1'b1, D_V, 1'b0);
			5'd7:  u = alu_op(X_V,  Y_V, 1'b0, 6'd28, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd8:  u = alu_op(X_V,  Y_V, 1'b1, 6'd31, FN_ADD, 1'b0, 1'b1, D_V, 1'b1);
			5'd9:  u = alu_op(X_V,  Y_V, 1'b1, 6'd31, FN_SUB, 1'b0, 1'b0, D_T, 1'b0);
			5'd10: u = alu_op(X_V,  Y_T, 1'b1, 6'd31, FN_SUB, 1'b0, 1'b1, D_V, 1'b0);
			5'd11: u = alu_op(X_V,  Y_V, 1'b0, 6'd28, FN_XOR, 1'b0, 1'b0, D_T, 1'b0);
			5'd12: u = alu_op(X_V,  Y_T, 1'b0, 6'd28, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd13: u = mul_op(2'd0, C_INV21);
			5'd14: u = mul_op(2'd1, C_INV21);
			5'd15: u = mul_op(2'd2, C_INV21);
			5'd16: u = mul_op(2'd3, C_INV21);
			5'd17: u = alu_op(X_V,  Y_V, 1'b0, 6'd14, FN_XOR, 1'b0, 1'b0, D_T, 1'b0);
			5'd18: u = alu_op(X_V,  Y_T, 1'b0, 6'd14, FN_XOR, 1'b0, 1'b0, D_T, 1'b0);
			5'd19: u = alu_op(X_V,  Y_T, 1'b0, 6'd14, FN_XOR, 1'b0, 1'b0, D_T, 1'b0);
			5'd20: u = alu_op(X_V,  Y_T, 1'b0, 6'd14, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd21: u = mul_op(2'd0, C_INV265);
			5'd22: u = mul_op(2'd1, C_INV265);
			5'd23: u = mul_op(2'd2, C_INV265);
			5'd24: u = mul_op(2'd3, C_INV265);
			5'd25: u = alu_op(X_V,  Y_V, 1'b0, 6'd24, FN_XOR, 1'b0, 1'b0, D_T, 1'b0);
			5'd26: u = alu_op(X_V,  Y_T, 1'b0, 6'd24, FN_XOR, 1'b0, 1'b0, D_V, 1'b0);
			5'd27: u = alu_op(X_V,  Y_NV, 1'b1, 6'd21, FN_SUB, 1'b1, 1'b0, D_T, 1'b0);
			5'd28: u = alu_op(X_V,  Y_T, 1'b1, 6'd21, FN_SUB, 1'b1, 1'b0, D_T, 1'b0);
			5'd29: u = alu_op(X_V,  Y_T, 1'b1, 6'd21, FN_SUB, 1'b1, 1'b1, D_V, 1'b1);
			default: u = '0;
		endcase
		return u;
	endfunction

	function automatic logic [7:0] letter(logic [1:0] code);
		logic [7:0] c;
		unique case (code)
			2'd0: c = CHAR_A;
			2'd1: c = CHAR_C;
			2'd2: c = CHAR_T;
			default: c = CHAR_G;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kmer_invertible_hash_codec.sv =====
// K-mer invertible hash codec: packs nucleotides, hashes on the last one,
// and inverts hash values back to k characters. Uses kihc_pkg and the assert macros.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------
//   item     | in        | item_valid/item_stall | item_t   (item)
//   result   | out       | result_valid/stall    | result_t (result)
//   cfg      | in        | cfg_valid/cfg_ready   | kmer_length (cfg_data)
//
// A character not marked last is packed into the accumulator when accepted. A marked
// last character is packed, then the forward program runs on the shared adder/shifter
// before the hash result is offered. A decode item runs the inverse program (two
// constant multiplies of four steps on one 32x32 multiplier), then emits k characters.
// Reset: asynchronous, clears the accumulator, error flag and kmer_length to 31.
// A stalled result holds; the sequencer waits in its emit state meanwhile.
`default_nettype none

`include "kmer_invertible_hash_codec_assert.svh"

module kmer_invertible_hash_codec
	import kihc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_valid,
	output logic         cfg_ready,
	input  wire logic [5:0] cfg_data,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]  state_q;
	logic [4:0]  pc_q;
	logic [4:0]  cnt_q;
	logic        dec_q;
	logic        err_out_q;
	logic [5:0]  kmer_length_q;
	logic [63:0] packed_q;
	logic        error_seen_q;
	logic [63:0] v_q;
	logic [63:0] t_q;
	logic [63:0] prod_q;
	logic        rvalid_q;
	result_t     result_q;

	logic [5:0]  k_eff;
	logic [5:0]  k_m1;
	logic [6:0]  mask_bits;
	logic [63:0] mask;
	logic        accept;
	logic        slot_free;
	logic        sym_ok;
	logic [1:0]  sym_code;
	logic [63:0] packed_next;
	logic        error_next;
	uop_t        uop;
	logic [63:0] x_val;
	logic [63:0] y_src;
	logic [63:0] y_val;
	logic [63:0] alu_raw;
	logic [63:0] alu_res;
	logic [31:0] mul_a;
	logic [63:0] mul_const;
	logic [31:0] mul_c;
	logic [63:0] prod_d;
	logic [1:0]  dec_code;
	logic        emit_last;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = rvalid_q;
	assign result       = result_q;
	assign slot_free    = !rvalid_q || !result_stall;

	// Clamp k to 1..MAX_K; mask covers the low 2k bits
	always_comb begin
		priority if (kmer_length_q == 6'd0) begin
			k_eff = 6'd1;
		end else if (kmer_length_q > 6'(MAX_K)) begin
			k_eff = 6'(MAX_K);
		end else begin
			k_eff = kmer_length_q;
		end
	end
	assign k_m1      = k_eff - 6'd1;
	assign mask_bits = {k_eff, 1'b0};
	assign mask      = {64{1'b1}} >> (7'd64 - mask_bits);

	always_comb begin
		sym_ok   = 1'b1;
		sym_code = 2'd0;
		unique case (item.symbol)
			CHAR_A: sym_code = 2'd0;
			CHAR_C: sym_code = 2'd1;
			CHAR_T: sym_code = 2'd2;
			CHAR_G: sym_code = 2'd3;
			default: sym_ok = 1'b0;
		endcase
	end
	assign packed_next = sym_ok ? {packed_q[61:0], sym_code} : packed_q;
	assign error_next  = error_seen_q || !sym_ok;

	// Shared unit: one add/sub/xor over a selected operand and a shifted one, optionally inverted and masked
	assign uop = ucode(pc_q);

	always_comb begin
		unique case (uop.xsel)
			X_V:     x_val = v_q;
			X_T:     x_val = t_q;
			X_NV:    x_val = ~v_q;
			default: x_val = prod_q;
		endcase
		unique case (uop.ysel)
			Y_V:     y_src = v_q;
			Y_T:     y_src = t_q;
			Y_NV:    y_src = ~v_q;
			Y_P:     y_src = prod_q;
			default: y_src = 64'd0;
		endcase
		y_val = uop.shl ? (y_src << uop.shamt) : (y_src >> uop.shamt);
		unique case (uop.fn)
			FN_ADD:  alu_raw = x_val + y_val;
			FN_SUB:  alu_raw = x_val - y_val;
			default: alu_raw = x_val ^ y_val;
		endcase
		alu_res = uop.inv ? ~alu_raw : alu_raw;
		if (uop.msk) begin
			alu_res = alu_res & mask;
		end
	end

	assign mul_const = (uop.mul_csel == C_INV265) ? INV265 : INV21;
	assign mul_a     = uop.mul_vhi ? v_q[63:32] : v_q[31:0];
	assign mul_c     = uop.mul_chi ? mul_const[63:32] : mul_const[31:0];
	assign prod_d    = mul_a * mul_c;

	assign dec_code  = v_q[{cnt_q, 1'b0} +: 2];
	assign emit_last = !dec_q || (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pc_q          <= UC_FWD_START;
			cnt_q         <= 5'd0;
			dec_q         <= 1'b0;
			err_out_q     <= 1'b0;
			kmer_length_q <= KMER_LENGTH_RESET;
			packed_q      <= 64'd0;
			error_seen_q  <= 1'b0;
			rvalid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kmer_length_q <= cfg_data;
			end
			if (state_q == S_EMIT && slot_free) begin
				rvalid_q <= 1'b1;
			end else if (!result_stall) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.command == CMD_DECODE) begin
							dec_q   <= 1'b1;
							pc_q    <= UC_INV_START;
							state_q <= S_RUN;
						end else if (item.end_of_kmer) begin
							// hash the updated value; clear for the next k-mer
							dec_q        <= 1'b0;
							err_out_q    <= error_next;
							packed_q     <= 64'd0;
							error_seen_q <= 1'b0;
							pc_q         <= UC_FWD_START;
							state_q      <= S_RUN;
						end else begin
							packed_q     <= packed_next;
							error_seen_q <= error_next;
						end
					end
				end
				S_RUN: begin
					pc_q <= pc_q + 5'd1;
					if (uop.last) begin
						cnt_q   <= k_m1[4:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - 5'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= (item.command == CMD_DECODE) ? item.hash_in : packed_next;
		end else if (state_q == S_RUN) begin
			if (uop.dst == D_V) begin
				v_q <= alu_res;
			end
			if (uop.dst == D_T) begin
				t_q <= alu_res;
			end
			if (uop.mul_en) begin
				prod_q <= prod_d;
			end
		end
		if (state_q == S_EMIT && slot_free) begin
			result_q.kind       <= dec_q ? KIND_CHAR : KIND_HASH;
			result_q.hash_out   <= dec_q ? 64'd0 : v_q;
			result_q.char_out   <= dec_q ? letter(dec_code) : 8'd0;
			result_q.bad_symbol <= dec_q ? 1'b0 : err_out_q;
			result_q.final_res  <= emit_last;
		end
	end

	`KIHC_ASSERT_NOW(a_pc_in_program, state_q == S_RUN, pc_q <= UC_LAST,
		"microprogram counter ran past the program")
	`KIHC_ASSERT_NOW(a_char_is_base,
		result_valid && result.kind == KIND_CHAR,
		result.char_out == CHAR_A || result.char_out == CHAR_C ||
		result.char_out == CHAR_T || result.char_out == CHAR_G,
		"decoded character is not a nucleotide")
	`KIHC_ASSERT_NOW(a_hash_masked,
		result_valid && result.kind == KIND_HASH,
		(result.hash_out & ~mask) == 64'd0 && result.final_res,
		"hash result has bits above 2k or is not final")
	`KIHC_ASSERT_NEXT(a_decode_continues,
		state_q == S_EMIT && dec_q && slot_free && cnt_q != 5'd0,
		state_q == S_EMIT,
		"decode left emit before the last character")

endmodule

`default_nettype wire
